/* design/smpq_pkg.sv */
// ----------------------------------------------------------------------------
// smpq_pkg: shared types for the sorted-chain priority queue
// Entry layout, operation codes and the command bus broadcast to every cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 8;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [RANK_W-1:0]  rank_t;

  // Operation codes carried on opcode_i
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    value_t value;
    rank_t  rank;
  } entry_t;

  // Command broadcast along the chain; push and pop are already qualified
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } cmd_t;

endpackage : smpq_pkg

`default_nettype wire

/* design/smpq_cell.sv */
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted priority chain
// Holds one entry, compares it with the pushed rank and shifts with neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire logic                clk_i,
  input  wire smpq_pkg::cmd_t      cmd_i,
  input  wire logic [CNT_W-1:0]    occ_i,
  input  wire smpq_pkg::entry_t    left_entry_i,
  input  wire logic                left_gt_i,
  input  wire smpq_pkg::entry_t    right_entry_i,
  output      smpq_pkg::entry_t    entry_o,
  output      logic                gt_o
);
  import smpq_pkg::*;

  entry_t entry_q, entry_d;
  logic   occupied;

  assign occupied = CNT_W'(IDX) < occ_i;
  // Strictly greater: equal ranks stay ahead of the new entry
  assign gt_o     = occupied && (entry_q.rank > cmd_i.entry.rank);
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.push) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (!occupied || gt_o) begin
        entry_d = cmd_i.entry;
      end
    end else if (cmd_i.pop) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule : smpq_cell

`default_nettype wire

/* design/stable_min_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// stable_min_priority_queue_core: bounded min-priority queue, stable on ties
// Sorted chain of cells; the smallest rank sits in cell 0 (the head).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per
//   transaction: opcode_i selects push (with entry_value_i, entry_rank_i) or
//   pop of the head. Output channel (out_valid_o / out_stall_i) returns one
//   result transaction per operation: head entry after the operation (zero
//   when empty), is_empty_o, is_full_o and op_error_o.
//   The result is valid in the cycle after the input is accepted.
//   Throughput: one operation per cycle while out_stall_i is low; every cell
//   updates in parallel, the comparison against the pushed rank being done
//   locally in each cell and the shift being a one-step move to a neighbor.
//   A push to a full queue is rejected and a pop from an empty queue leaves
//   the queue unchanged; both raise op_error_o.
//   Reset clears the occupancy, the output valid and the error flag; slot
//   contents are not reset and are never shown before they are written.
//   While the receiver stalls, the pending result holds and in_stall_o is
//   raised, so no new operation is taken until the result is drained (a new
//   operation may be taken in the same cycle the old result leaves).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] entry_value_i,
  input  wire logic [7:0]         entry_rank_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic signed [31:0] head_value_o,
  output      logic [7:0]         head_rank_o,
  output      logic               is_empty_o,
  output      logic               is_full_o,
  output      logic               op_error_o
);
  import smpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             out_valid_q;
  logic             op_error_q, op_error_d;
  logic             accept;
  logic             empty, full;
  cmd_t             cmd;

  entry_t entry_w [CAPACITY];
  logic   gt_w    [CAPACITY];

  // Hold the input while a result still waits at the output
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign empty = (occ_q == '0);
  assign full  = (occ_q == CNT_W'(CAPACITY));

  // Qualify the operation: drop a push when full and a pop when empty
  always_comb begin
    cmd.entry.value = value_t'(entry_value_i);
    cmd.entry.rank  = entry_rank_i;
    cmd.push        = accept && (opcode_i == OP_PUSH) && !full;
    cmd.pop         = accept && (opcode_i == OP_POP) && !empty;
  end

  always_comb begin
    occ_d      = occ_q;
    op_error_d = op_error_q;
    if (accept) begin
      op_error_d = !(cmd.push || cmd.pop);
      if (cmd.push) begin
        occ_d = occ_q + CNT_W'(1);
      end else if (cmd.pop) begin
        occ_d = occ_q - CNT_W'(1);
      end
    end
  end

  // Chain of cells: each looks at its left neighbor on push, right on pop
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_gt;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid_l
      assign left_entry = entry_w[i-1];
      assign left_gt    = gt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid_r
      assign right_entry = entry_w[i+1];
    end

    smpq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ_q),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .gt_o          (gt_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      op_error_q  <= 1'b0;
    end else begin
      occ_q      <= occ_d;
      op_error_q <= op_error_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The queue state only moves on an accepted transaction, so the result
  // reads straight from the head cell and the occupancy
  assign out_valid_o  = out_valid_q;
  assign head_value_o = empty ? '0 : $signed(entry_w[0].value);
  assign head_rank_o  = empty ? '0 : entry_w[0].rank;
  assign is_empty_o   = empty;
  assign is_full_o    = full;
  assign op_error_o   = op_error_q;

endmodule : stable_min_priority_queue_core

`default_nettype wire

/* design/smpq_chk.sv */
// ----------------------------------------------------------------------------
// smpq_chk: port-level checks for the priority queue
// Watches handshakes and result flags over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smpq_chk (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               opcode_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] head_value_o,
  input wire logic [7:0]         head_rank_o,
  input wire logic               is_empty_o,
  input wire logic               is_full_o,
  input wire logic               op_error_o
);
  import smpq_pkg::*;

  // Every accepted transaction yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("no result after accepted transaction");

  // An empty queue shows a zero head
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (head_value_o == '0 && head_rank_o == '0))
    else $error("empty queue shows nonzero head");

  // Empty and full never show together
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_empty_o && is_full_o))
    else $error("empty and full both set");

  // A successful push never leaves the queue empty
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && opcode_i == OP_PUSH)
      |=> (op_error_o || !is_empty_o))
    else $error("queue empty after successful push");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i)
      |=> (out_valid_o && $stable(head_value_o) && $stable(head_rank_o)
           && $stable(op_error_o)))
    else $error("stalled result changed");

endmodule : smpq_chk

bind stable_min_priority_queue_core smpq_chk u_smpq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .head_value_o (head_value_o),
  .head_rank_o  (head_rank_o),
  .is_empty_o   (is_empty_o),
  .is_full_o    (is_full_o),
  .op_error_o   (op_error_o)
);

`default_nettype wire
